### rtl/core/ffa_pkg.sv
// Shared constants, codes and types of the first-fit region allocator.
package ffa_pkg;

    // Table geometry
    localparam int MAX_REGIONS = 64;
    localparam int ADDR_W      = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // Field widths
    localparam int DATA_W  = 32;
    localparam int ALIGN_W = 17;
    localparam int STAT_W  = 2;

    // Wide arithmetic for candidate offsets and sums (no wrap)
    localparam int CW        = 36;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = CW / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] BLOCK_BYTES_RST = 32'd524288000;

    // Commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                command;
        logic [DATA_W-1:0]   request_size;
        logic [ALIGN_W-1:0]  alignment;
        logic [DATA_W-1:0]   release_offset;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [DATA_W-1:0]   region_offset;
        logic [DATA_W-1:0]   region_size;
    } t_result;

    // One stored region
    typedef struct packed {
        logic [DATA_W-1:0]   start;
        logic [DATA_W-1:0]   length;
    } t_entry;

    typedef struct packed {
        logic                start;
        logic [CW-1:0]       dividend;
        logic [ALIGN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ALIGN_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        t_entry              wr_data;
    } t_ram_cmd;

endpackage

### rtl/core/ffa_if.sv
// Handshake channel interfaces: request items, result items, configuration writes.
interface ffa_req_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [DATA_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  alignment;
    logic [DATA_W-1:0]   release_offset;

    modport source (
        output valid, command, request_size, alignment, release_offset,
        input  ready
    );
    modport sink (
        input  valid, command, request_size, alignment, release_offset,
        output ready
    );
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   region_offset;
    logic [DATA_W-1:0]   region_size;

    modport source (
        output valid, status, region_offset, region_size,
        input  ready
    );
    modport sink (
        input  valid, status, region_offset, region_size,
        output ready
    );
endinterface

interface ffa_cfg_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   block_bytes;

    modport source (
        output valid, block_bytes,
        input  ready
    );
    modport sink (
        input  valid, block_bytes,
        output ready
    );
endinterface

### rtl/core/ffa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### rtl/core/ffa_rem.sv
// Iterative remainder unit: dividend mod alignment, four quotient bits per cycle.
module ffa_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffa_pkg::t_div_req i_req,
    output ffa_pkg::t_div_rsp o_rsp
);
    import ffa_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CW-1:0]        r_dvd;
    logic [ALIGN_W-1:0]   r_div;
    logic [ALIGN_W-1:0]   r_rem;

    logic [CW-1:0]        n_dvd;
    logic [ALIGN_W-1:0]   n_rem;
    logic [ALIGN_W:0]     w_trial;

    // Restoring steps: shift in one dividend bit, subtract divisor if it fits
    always_comb begin
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_trial = {n_rem, n_dvd[CW-1]};
            if (w_trial >= {1'b0, r_div}) begin
                w_trial = w_trial - {1'b0, r_div};
            end
            n_rem = w_trial[ALIGN_W-1:0];
            n_dvd = {n_dvd[CW-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule

### rtl/core/ffa_ctrl.sv
// Sequencer: size rounding, first-fit walk, sorted insertion and release over the table RAM.
module ffa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ffa_pkg::t_item                i_item,
    input  logic [ffa_pkg::DATA_W-1:0]    i_block_bytes,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ffa_pkg::t_result              o_res,
    output ffa_pkg::t_div_req             o_div_req,
    input  ffa_pkg::t_div_rsp             i_div_rsp,
    output ffa_pkg::t_ram_cmd             o_ram,
    input  ffa_pkg::t_entry               i_ram_rdata
);
    import ffa_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SZ_WAIT = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_WK_RD   = 4'd3;
    localparam logic [3:0] S_WK_EV   = 4'd4;
    localparam logic [3:0] S_EW_WAIT = 4'd5;
    localparam logic [3:0] S_SH_RD   = 4'd6;
    localparam logic [3:0] S_SH_EV   = 4'd7;
    localparam logic [3:0] S_RL_RD   = 4'd8;
    localparam logic [3:0] S_RL_EV   = 4'd9;
    localparam logic [3:0] S_RS_RD   = 4'd10;
    localparam logic [3:0] S_RS_EV   = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    logic [3:0]          r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_idx,     n_idx;
    logic [ALIGN_W-1:0]  r_align,   n_align;
    logic [DATA_W-1:0]   r_off,     n_off;
    logic [CW-1:0]       r_val,     n_val;
    logic [CW-1:0]       r_size,    n_size;
    logic [CW-1:0]       r_cand,    n_cand;
    t_result             r_res,     n_res;

    logic [ALIGN_W-1:0]  w_align_in;
    logic [CW-1:0]       w_adj;
    logic [CW-1:0]       w_rounded;
    logic [CW-1:0]       w_s;
    logic [CW-1:0]       w_e;
    logic [CW-1:0]       w_cand_end;
    logic                w_overlap;
    logic                w_too_big;
    logic [CNT_W-1:0]    w_idx_m1;
    t_entry              w_new;

    // Arithmetic around the walk
    assign w_align_in = (i_item.alignment == '0) ? ALIGN_W'(1) : i_item.alignment;
    assign w_adj      = (i_div_rsp.rem == '0) ? '0 : CW'(r_align - i_div_rsp.rem);
    assign w_rounded  = r_val + w_adj;
    assign w_s        = CW'(i_ram_rdata.start);
    assign w_e        = CW'(i_ram_rdata.start) + CW'(i_ram_rdata.length);
    assign w_cand_end = r_cand + r_size;
    // touching counts as overlap
    assign w_overlap  = (w_cand_end >= w_s) && (w_e >= r_cand);
    assign w_too_big  = w_cand_end > CW'(i_block_bytes);
    assign w_idx_m1   = r_idx - 1'b1;
    assign w_new      = '{start: r_cand[DATA_W-1:0], length: r_size[DATA_W-1:0]};

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_align = r_align;
        n_off   = r_off;
        n_val   = r_val;
        n_size  = r_size;
        n_cand  = r_cand;
        n_res   = r_res;

        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_val;
        o_div_req.divisor  = r_align;

        o_ram.rd_en   = 1'b0;
        o_ram.rd_addr = r_idx[ADDR_W-1:0];
        o_ram.wr_en   = 1'b0;
        o_ram.wr_addr = r_idx[ADDR_W-1:0];
        o_ram.wr_data = w_new;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_align = w_align_in;
                    n_off   = i_item.release_offset;
                    n_cand  = '0;
                    n_idx   = '0;
                    n_res   = '{status: ST_OK, region_offset: '0, region_size: '0};
                    if (i_item.command == CMD_RELEASE) begin
                        n_state = S_RL_RD;
                    end else if (r_count >= CNT_W'(MAX_REGIONS)) begin
                        n_res.status = ST_FULL;
                        n_state      = S_FIN;
                    end else begin
                        // round the request size up to the alignment
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = CW'(i_item.request_size);
                        o_div_req.divisor  = w_align_in;
                        n_val              = CW'(i_item.request_size);
                        n_state            = S_SZ_WAIT;
                    end
                end
            end
            S_SZ_WAIT: begin
                if (i_div_rsp.done) begin
                    n_size  = w_rounded;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_too_big) begin
                    n_res.status = ST_NO_SPACE;
                    n_state      = S_FIN;
                end else if (r_idx == r_count) begin
                    // walk done; insertion scans down from the top
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_WK_RD;
                end
            end
            S_WK_RD: begin
                o_ram.rd_en = 1'b1;
                n_state     = S_WK_EV;
            end
            S_WK_EV: begin
                n_idx = r_idx + 1'b1;
                if (w_overlap) begin
                    // move candidate past this region, aligned
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = w_e;
                    n_val              = w_e;
                    n_state            = S_EW_WAIT;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_EW_WAIT: begin
                if (i_div_rsp.done) begin
                    n_cand  = w_rounded;
                    n_state = S_CHECK;
                end
            end
            S_SH_RD: begin
                if (r_idx == '0) begin
                    o_ram.wr_en = 1'b1;
                    n_count     = r_count + 1'b1;
                    n_res       = '{status: ST_OK, region_offset: r_cand[DATA_W-1:0],
                                    region_size: r_size[DATA_W-1:0]};
                    n_state     = S_FIN;
                end else begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = w_idx_m1[ADDR_W-1:0];
                    n_state       = S_SH_EV;
                end
            end
            S_SH_EV: begin
                o_ram.wr_en = 1'b1;
                if (w_s > r_cand) begin
                    // entry starts after the new one: move it up a slot
                    o_ram.wr_data = i_ram_rdata;
                    n_idx         = w_idx_m1;
                    n_state       = S_SH_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_res   = '{status: ST_OK, region_offset: r_cand[DATA_W-1:0],
                                region_size: r_size[DATA_W-1:0]};
                    n_state = S_FIN;
                end
            end
            S_RL_RD: begin
                if (r_idx == r_count) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_FIN;
                end else begin
                    o_ram.rd_en = 1'b1;
                    n_state     = S_RL_EV;
                end
            end
            S_RL_EV: begin
                n_idx = r_idx + 1'b1;
                if (i_ram_rdata.start == r_off) begin
                    n_state = S_RS_RD;
                end else begin
                    n_state = S_RL_RD;
                end
            end
            S_RS_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_ram.rd_en = 1'b1;
                    n_state     = S_RS_EV;
                end
            end
            S_RS_EV: begin
                // close the gap: move entry down a slot
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = w_idx_m1[ADDR_W-1:0];
                o_ram.wr_data = i_ram_rdata;
                n_idx         = r_idx + 1'b1;
                n_state       = S_RS_RD;
            end
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_align <= n_align;
        r_off   <= n_off;
        r_val   <= n_val;
        r_size  <= n_size;
        r_cand  <= n_cand;
        r_res   <= n_res;
    end

    assign o_res = r_res;

    // Checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REGIONS))
        else $error("region count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
                     r_count == $past(r_count) - 1'b1))
        else $error("region count moved by more than one");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.wr_en |-> ({1'b0, o_ram.wr_addr} <= r_count))
        else $error("table write beyond the filled part");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |=> (r_state == S_SZ_WAIT || r_state == S_EW_WAIT))
        else $error("remainder started without waiting for it");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_ram.wr_en && !o_ram.rd_en))
        else $error("table access while idle");
endmodule

### rtl/core/first_fit_region_allocator_top.sv
// An allocate rounds the size up to the alignment, then walks the table; where the candidate
// overlaps a region it moves past it, aligned by the 9-step remainder unit. Regions that start
// after the new one move up a slot to make room; a full table gets ST_FULL without a walk. A
// release searches for the entry and shifts the later entries down a slot. One item at a time;
// the result waits in an output register, and the next item is taken the cycle after it lands.
// Reset (synchronous, active low) empties the table, sets block_bytes to 524288000; RAM kept.
module first_fit_region_allocator_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp,
    ffa_cfg_if.sink   i_cfg
);
    import ffa_pkg::*;

    logic [DATA_W-1:0] r_block_bytes;
    logic              r_out_valid;
    t_result           r_out;

    t_item             w_item;
    t_result           w_res;
    logic              w_res_valid;
    logic              w_res_ready;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    t_ram_cmd          w_ram;
    t_entry            w_ram_rdata;

    assign w_item = '{command: i_req.command, request_size: i_req.request_size,
                      alignment: i_req.alignment, release_offset: i_req.release_offset};

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
        end else if (i_cfg.valid) begin
            r_block_bytes <= i_cfg.block_bytes;
        end
    end

    ffa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .o_in_ready    (i_req.ready),
        .i_item        (w_item),
        .i_block_bytes (r_block_bytes),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_ram         (w_ram),
        .i_ram_rdata   (w_ram_rdata)
    );

    ffa_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    ffa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram.wr_en),
        .i_wr_addr (w_ram.wr_addr),
        .i_wr_data (w_ram.wr_data),
        .i_rd_en   (w_ram.rd_en),
        .i_rd_addr (w_ram.rd_addr),
        .o_rd_data (w_ram_rdata)
    );

    // Output register
    assign w_res_ready = !r_out_valid || o_rsp.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.region_offset = r_out.region_offset;
    assign o_rsp.region_size   = r_out.region_size;
endmodule
